/* rtl/dtprg_pkg.sv */
package dtprg_pkg;

    // Field widths fixed by the step and run formats
    localparam int LANE_W  = 6;
    localparam int DUR_W   = 16;
    localparam int TICKS_W = 17;  // duration plus correction, floored at one tick
    localparam int RUN_W   = 18;
    localparam int TOTAL_W = 24;
    localparam int DEAD_W  = 12;
    localparam int TRIM_W  = 11;
    localparam int MIN_W   = 10;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;

    localparam int RUN_MAX   = 262143;
    localparam int TOTAL_MAX = 16777215;
    localparam logic [MIN_W-1:0] MIN_ACTIVE_RESET = 10'd20;

    // Job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_TIME  = 2'd0,
        REG_RISE_TRIM  = 2'd1,
        REG_FALL_TRIM  = 2'd2,
        REG_MIN_ACTIVE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [DEAD_W-1:0] dead_time;
        logic [TRIM_W-1:0] rise_trim;
        logic [TRIM_W-1:0] fall_trim;
        logic [MIN_W-1:0]  min_active;
    } cfg_t;

    typedef struct packed {
        logic [LANE_W-1:0]  on;
        logic [LANE_W-1:0]  chg;
        logic [TICKS_W-1:0] ticks;
        logic               rise;
    } step_t;

    // One job: runs of step a, with step b following
    typedef struct packed {
        step_t              a;
        logic [LANE_W-1:0]  b_chg;
        logic               b_rise;
        logic               fin;
        logic [TOTAL_W-1:0] total;
    } job_t;

    typedef struct packed {
        logic [LANE_W-1:0]  lane_value;
        logic [RUN_W-1:0]   run_length;
        logic               dead_run;
        logic               clamped;
        logic [TOTAL_W-1:0] pattern_samples;
        logic               final_run;
    } run_t;

endpackage

/* rtl/dead_time_pattern_run_generator_core.sv */
// Channel   Handshake          Beat
// steps     push / full        lanes_on, lanes_changing, step_ticks,
//                              correction_ticks, rising_edge, last_step
// runs      empty / pop        lane_value, run_length, dead_run, clamped,
//                              pattern_samples, final_run
// config    cfg_write          cfg_index, cfg_data (no wait, no read-back)
//
// The front takes one step per cycle while the 4-entry job queue has room; the
// last step of a pattern with a held step issues two jobs and holds the front
// until its wrap job has been issued.
// The back emits one run per cycle while the run queue has room; each job gives
// an active run, plus a dead-time run when dead time applies.
// A 2-entry run queue decouples the back from pop stalls.
// Reset clears all control state; registers return to 0 except min_active (20).
module dead_time_pattern_run_generator_core
    import dtprg_pkg::*;
#(
    parameter int SAMPLES_PER_TICK = 2,
    parameter int MAX_STEPS        = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [LANE_W-1:0]       lanes_on,
    input  logic [LANE_W-1:0]       lanes_changing,
    input  logic [DUR_W-1:0]        step_ticks,
    input  logic signed [DUR_W-1:0] correction_ticks,
    input  logic                    rising_edge,
    input  logic                    last_step,
    output logic                    empty,
    input  logic                    pop,
    output logic [LANE_W-1:0]       lane_value,
    output logic [RUN_W-1:0]        run_length,
    output logic                    dead_run,
    output logic                    clamped,
    output logic [TOTAL_W-1:0]      pattern_samples,
    output logic                    final_run,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic job_push;
    job_t job_in;
    logic job_full;
    logic job_empty;
    job_t job_head;
    logic job_pop;
    logic res_push;
    run_t res_in;
    logic res_full;
    run_t res_head;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEAD_TIME:  cfg_next.dead_time  = cfg_data[DEAD_W-1:0];
                REG_RISE_TRIM:  cfg_next.rise_trim  = cfg_data[TRIM_W-1:0];
                REG_FALL_TRIM:  cfg_next.fall_trim  = cfg_data[TRIM_W-1:0];
                REG_MIN_ACTIVE: cfg_next.min_active = cfg_data[MIN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_time  <= '0;
            cfg_reg.rise_trim  <= '0;
            cfg_reg.fall_trim  <= '0;
            cfg_reg.min_active <= MIN_ACTIVE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accept and classify steps into jobs
    dtprg_front #(
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK),
        .MAX_STEPS        (MAX_STEPS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .lanes_on         (lanes_on),
        .lanes_changing   (lanes_changing),
        .step_ticks       (step_ticks),
        .correction_ticks (correction_ticks),
        .rising_edge      (rising_edge),
        .last_step        (last_step),
        .job_push         (job_push),
        .job_data         (job_in),
        .job_full         (job_full)
    );

    // Job queue between front and back
    dtprg_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_head),
        .empty (job_empty)
    );

    // Back: turn jobs into active and dead-time runs
    dtprg_back #(
        .SAMPLES_PER_TICK (SAMPLES_PER_TICK)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res_data  (res_in),
        .res_full  (res_full)
    );

    // Run output queue
    dtprg_fifo #(
        .WIDTH ($bits(run_t)),
        .DEPTH (OUT_DEPTH)
    ) u_run_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign lane_value      = res_head.lane_value;
    assign run_length      = res_head.run_length;
    assign dead_run        = res_head.dead_run;
    assign clamped         = res_head.clamped;
    assign pattern_samples = res_head.pattern_samples;
    assign final_run       = res_head.final_run;

endmodule

/* rtl/dtprg_fifo.sv */
module dtprg_fifo
    import dtprg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

/* rtl/dtprg_front.sv */
module dtprg_front
    import dtprg_pkg::*;
#(
    parameter int SAMPLES_PER_TICK = 2,
    parameter int MAX_STEPS        = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [LANE_W-1:0]       lanes_on,
    input  logic [LANE_W-1:0]       lanes_changing,
    input  logic [DUR_W-1:0]        step_ticks,
    input  logic signed [DUR_W-1:0] correction_ticks,
    input  logic                    rising_edge,
    input  logic                    last_step,
    output logic                    job_push,
    output job_t                    job_data,
    input  logic                    job_full
);

    localparam int SMP_W = TICKS_W + $clog2(SAMPLES_PER_TICK + 1);
    localparam int SUM_W = TOTAL_W + 1;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    step_t              held_reg, held_next;
    step_t              first_reg, first_next;
    logic               have_held_reg, have_held_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pend_valid_reg, pend_valid_next;
    job_t               pend_reg, pend_next;

    logic                   accept;
    logic signed [DUR_W+1:0] tick_sum;
    step_t                  cur;
    logic [SMP_W-1:0]       cur_samples;
    logic [CNT_W-1:0]       count_new;
    logic                   is_last;
    logic [SUM_W-1:0]       total_sum;
    logic [TOTAL_W-1:0]     total_new;
    job_t                   job_held;
    job_t                   job_last;

    assign full   = pend_valid_reg || job_full;
    assign accept = push && !full;

    // Classify the incoming step
    always_comb
    begin
        tick_sum = $signed({2'b00, step_ticks})
                 + $signed({{2{correction_ticks[DUR_W-1]}}, correction_ticks});
        cur.on   = lanes_on;
        cur.chg  = lanes_changing;
        cur.rise = rising_edge;
        if (tick_sum < $signed((DUR_W+2)'(1)))
        begin
            cur.ticks = TICKS_W'(1);
        end
        else
        begin
            cur.ticks = tick_sum[TICKS_W-1:0];
        end
        cur_samples = SMP_W'(cur.ticks) * SMP_W'(SAMPLES_PER_TICK);
        count_new   = have_held_reg ? count_reg + 1'b1 : CNT_W'(1);
        is_last     = last_step || (count_new >= CNT_W'(MAX_STEPS));
        total_sum   = (have_held_reg ? SUM_W'(total_reg) : '0) + SUM_W'(cur_samples);
        if (total_sum > SUM_W'(TOTAL_MAX))
        begin
            total_new = TOTAL_W'(TOTAL_MAX);
        end
        else
        begin
            total_new = total_sum[TOTAL_W-1:0];
        end
    end

    // Jobs: held step followed by this one, and this one wrapping to the first
    always_comb
    begin
        job_held.a      = held_reg;
        job_held.b_chg  = cur.chg;
        job_held.b_rise = cur.rise;
        job_held.fin    = 1'b0;
        job_held.total  = '0;

        job_last.a      = cur;
        job_last.b_chg  = have_held_reg ? first_reg.chg : cur.chg;
        job_last.b_rise = have_held_reg ? first_reg.rise : cur.rise;
        job_last.fin    = 1'b1;
        job_last.total  = total_new;
    end

    // Job issue and pattern state
    always_comb
    begin
        job_push        = 1'b0;
        job_data        = job_held;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        held_next       = held_reg;
        first_next      = first_reg;
        have_held_next  = have_held_reg;
        total_next      = total_reg;
        count_next      = count_reg;

        if (pend_valid_reg)
        begin
            job_data = pend_reg;
            if (!job_full)
            begin
                job_push        = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (have_held_reg)
            begin
                job_push = 1'b1;
                job_data = job_held;
                if (is_last)
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = job_last;
                end
            end
            else if (is_last)
            begin
                job_push = 1'b1;
                job_data = job_last;
            end

            if (is_last)
            begin
                have_held_next = 1'b0;
                total_next     = '0;
                count_next     = '0;
            end
            else
            begin
                held_next      = cur;
                have_held_next = 1'b1;
                total_next     = total_new;
                count_next     = count_new;
                if (!have_held_reg)
                begin
                    first_next = cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_held_reg  <= 1'b0;
            total_reg      <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            have_held_reg  <= have_held_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg  <= held_next;
        first_reg <= first_next;
        pend_reg  <= pend_next;
    end

endmodule

/* rtl/dtprg_back.sv */
module dtprg_back
    import dtprg_pkg::*;
#(
    parameter int SAMPLES_PER_TICK = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic job_empty,
    input  job_t job_head,
    output logic job_pop,
    output logic res_push,
    output run_t res_data,
    input  logic res_full
);

    localparam int SMP_W = TICKS_W + $clog2(SAMPLES_PER_TICK + 1);
    localparam int ACT_W = SMP_W + 3;

    job_t work_reg, work_next;
    logic work_valid_reg, work_valid_next;
    logic phase_reg, phase_next;

    logic [SMP_W-1:0]        dur;
    logic [DEAD_W-1:0]       dead;
    logic                    has_dead;
    logic [TRIM_W-1:0]       trim_a;
    logic [TRIM_W-1:0]       trim_b;
    logic signed [ACT_W-1:0] act;
    logic [RUN_W-1:0]        act_len;
    logic                    act_clamp;
    logic                    done;

    // Active run length: duration, dead time and edge trims, raised to min_active and capped at RUN_MAX
    always_comb
    begin
        dur      = SMP_W'(work_reg.a.ticks) * SMP_W'(SAMPLES_PER_TICK);
        dead     = (work_reg.b_chg != '0) ? cfg.dead_time : '0;
        has_dead = (dead != '0);
        if (work_reg.a.chg == '0)
        begin
            trim_a = '0;
        end
        else
        begin
            trim_a = work_reg.a.rise ? cfg.rise_trim : cfg.fall_trim;
        end
        if (work_reg.b_chg == '0)
        begin
            trim_b = '0;
        end
        else
        begin
            trim_b = work_reg.b_rise ? cfg.rise_trim : cfg.fall_trim;
        end
        act = $signed({{(ACT_W-SMP_W){1'b0}}, dur})
            - $signed({{(ACT_W-DEAD_W){1'b0}}, dead})
            + $signed({{(ACT_W-TRIM_W){trim_a[TRIM_W-1]}}, trim_a})
            - $signed({{(ACT_W-TRIM_W){trim_b[TRIM_W-1]}}, trim_b});
        act_clamp = 1'b0;
        if (act < $signed({{(ACT_W-MIN_W){1'b0}}, cfg.min_active}))
        begin
            act_len   = RUN_W'(cfg.min_active);
            act_clamp = 1'b1;
        end
        else if (act > $signed(ACT_W'(RUN_MAX)))
        begin
            act_len = RUN_W'(RUN_MAX);
        end
        else
        begin
            act_len = act[RUN_W-1:0];
        end
    end

    // Run beat: active run first, then the dead-time window if any
    always_comb
    begin
        if (phase_reg)
        begin
            res_data.lane_value      = work_reg.a.on & ~work_reg.b_chg;
            res_data.run_length      = RUN_W'(dead);
            res_data.dead_run        = 1'b1;
            res_data.clamped         = 1'b0;
            res_data.pattern_samples = work_reg.fin ? work_reg.total : '0;
            res_data.final_run       = work_reg.fin;
        end
        else
        begin
            res_data.lane_value      = work_reg.a.on;
            res_data.run_length      = act_len;
            res_data.dead_run        = 1'b0;
            res_data.clamped         = act_clamp;
            res_data.pattern_samples = (work_reg.fin && !has_dead) ? work_reg.total : '0;
            res_data.final_run       = work_reg.fin && !has_dead;
        end
    end

    assign res_push = work_valid_reg && !res_full;
    assign done     = res_push && (phase_reg || !has_dead);
    assign job_pop  = !job_empty && (!work_valid_reg || done);

    // Work register sequencing
    always_comb
    begin
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        phase_next      = phase_reg;
        if (job_pop)
        begin
            work_next       = job_head;
            work_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (done)
        begin
            work_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (res_push)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import dtprg_pkg::*;

    localparam int TICK_SAMPLES = 2;
    localparam int STEP_CAP     = 64;
    localparam int SETTLE       = 16;      // cycles for the pipe to go quiet
    localparam int HOLD_CYCLES  = 80;      // long pop hold-off
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHUNK_STEPS  = 10;

    // DUT signals
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic [LANE_W-1:0]       lanes_on = '0;
    logic [LANE_W-1:0]       lanes_changing = '0;
    logic [DUR_W-1:0]        step_ticks = '0;
    logic signed [DUR_W-1:0] correction_ticks = '0;
    logic                    rising_edge = 1'b0;
    logic                    last_step = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [LANE_W-1:0]       lane_value;
    logic [RUN_W-1:0]        run_length;
    logic                    dead_run;
    logic                    clamped;
    logic [TOTAL_W-1:0]      pattern_samples;
    logic                    final_run;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;

    dead_time_pattern_run_generator_core #(
        .SAMPLES_PER_TICK(TICK_SAMPLES),
        .MAX_STEPS(STEP_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .lanes_on(lanes_on),
        .lanes_changing(lanes_changing),
        .step_ticks(step_ticks),
        .correction_ticks(correction_ticks),
        .rising_edge(rising_edge),
        .last_step(last_step),
        .empty(empty),
        .pop(pop),
        .lane_value(lane_value),
        .run_length(run_length),
        .dead_run(dead_run),
        .clamped(clamped),
        .pattern_samples(pattern_samples),
        .final_run(final_run),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bookkeeping
    int errors        = 0;
    int steps_sent    = 0;
    int runs_checked  = 0;
    int dead_seen     = 0;
    int clamp_seen    = 0;
    int patterns_done = 0;
    int reg_writes    = 0;
    int cycles        = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 61;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    // Run predictor state: pattern in progress and register copies
    step_t              held_step_q;
    step_t              opening_step;
    bit                 held_valid = 1'b0;
    logic [TOTAL_W-1:0] total_acc = '0;
    int                 step_no = 0;
    logic [DEAD_W-1:0]        dead_cfg = '0;
    logic signed [TRIM_W-1:0] rise_cfg = '0;
    logic signed [TRIM_W-1:0] fall_cfg = '0;
    logic [MIN_W-1:0]         min_cfg = MIN_ACTIVE_RESET;

    run_t fresh_runs[$];   // runs caused by the step just accepted
    run_t runs_due[$];     // runs still owed by the block

    // Directed stimulus rows: a step or a register write
    typedef struct {
        bit                      is_cfg;
        cfg_reg_t                idx;
        logic [CFG_W-1:0]        data;
        logic [LANE_W-1:0]       on;
        logic [LANE_W-1:0]       chg;
        logic [DUR_W-1:0]        dur;
        logic [DUR_W-1:0]        corr;
        bit                      rise;
        bit                      last;
        bit                      typed;
        run_t                    want;
    } row_t;

    row_t plan[$];

    function automatic run_t run_of(logic [LANE_W-1:0] val, int len, bit dead, bit clip,
                                    int total, bit fin);
        run_t r;
        r.lane_value      = val;
        r.run_length      = len[RUN_W-1:0];
        r.dead_run        = dead;
        r.clamped         = clip;
        r.pattern_samples = total[TOTAL_W-1:0];
        r.final_run       = fin;
        return r;
    endfunction

    function automatic row_t step_row(logic [LANE_W-1:0] on, logic [LANE_W-1:0] chg,
                                      logic [DUR_W-1:0] dur, logic [DUR_W-1:0] corr,
                                      bit rise, bit last, bit typed, run_t want);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx    = REG_DEAD_TIME;
        r.data   = '0;
        r.on     = on;
        r.chg    = chg;
        r.dur    = dur;
        r.corr   = corr;
        r.rise   = rise;
        r.last   = last;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic row_t cfg_row(cfg_reg_t idx, logic [CFG_W-1:0] data);
        row_t r;
        r        = step_row('0, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    // Edge trim of a step: none when no lane changes
    function automatic int edge_trim(step_t s);
        if (s.chg == '0)
            return 0;
        return s.rise ? int'(rise_cfg) : int'(fall_cfg);
    endfunction

    // Active run (and dead-time run) of step a when step b follows
    task automatic queue_runs(step_t a, step_t b, bit fin);
        int   dead;
        int   act;
        bit   clip;
        int   total;
        dead  = (b.chg != '0) ? int'(dead_cfg) : 0;
        act   = int'(a.ticks) * TICK_SAMPLES - dead + edge_trim(a) - edge_trim(b);
        clip  = act < int'(min_cfg);
        if (clip)
            act = int'(min_cfg);
        if (act > RUN_MAX)
            act = RUN_MAX;
        total = fin ? int'(total_acc) : 0;
        if (dead != 0)
        begin
            fresh_runs.push_back(run_of(a.on, act, 1'b0, clip, 0, 1'b0));
            fresh_runs.push_back(run_of(a.on & ~b.chg, dead, 1'b1, 1'b0, total, fin));
        end
        else
            fresh_runs.push_back(run_of(a.on, act, 1'b0, clip, total, fin));
    endtask

    // Advance the pattern by one accepted step; fills fresh_runs
    task automatic predict_step(logic [LANE_W-1:0] on, logic [LANE_W-1:0] chg,
                                logic [DUR_W-1:0] dur, logic signed [DUR_W-1:0] corr,
                                bit rise, bit last);
        int      t;
        longint  sum;
        step_t   cur;
        bit      ends;
        fresh_runs.delete();
        t = int'(dur) + int'(corr);
        if (t < 1)
            t = 1;
        cur.on    = on;
        cur.chg   = chg;
        cur.ticks = t[TICKS_W-1:0];
        cur.rise  = rise;
        if (!held_valid)
        begin
            step_no      = 0;
            total_acc    = '0;
            opening_step = cur;
        end
        step_no++;
        ends = last || (step_no >= STEP_CAP);
        sum  = longint'(total_acc) + longint'(t) * TICK_SAMPLES;
        total_acc = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
        if (held_valid)
            queue_runs(held_step_q, cur, 1'b0);
        if (ends)
        begin
            queue_runs(cur, opening_step, 1'b1);
            held_valid = 1'b0;
            total_acc  = '0;
            step_no    = 0;
            patterns_done++;
        end
        else
        begin
            held_step_q = cur;
            held_valid  = 1'b1;
        end
    endtask

    // Offer one step; returns once it is taken
    task automatic send_step(logic [LANE_W-1:0] on, logic [LANE_W-1:0] chg,
                             logic [DUR_W-1:0] dur, logic [DUR_W-1:0] corr,
                             bit rise, bit last, bit typed, run_t want);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push             <= 1'b1;
        lanes_on         <= on;
        lanes_changing   <= chg;
        step_ticks       <= dur;
        correction_ticks <= corr;
        rising_edge      <= rise;
        last_step        <= last;
        do
            @(posedge clk);
        while (full);
        predict_step(on, chg, dur, corr, rise, last);
        if (typed)
            runs_due.push_back(want);
        else
            foreach (fresh_runs[i])
                runs_due.push_back(fresh_runs[i]);
        steps_sent++;
    endtask

    // Wait until every owed run is out, then let the pipe settle
    task automatic drain();
        push <= 1'b0;
        while (runs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_DEAD_TIME:  dead_cfg = data[DEAD_W-1:0];
            REG_RISE_TRIM:  rise_cfg = data[TRIM_W-1:0];
            REG_FALL_TRIM:  fall_cfg = data[TRIM_W-1:0];
            REG_MIN_ACTIVE: min_cfg  = data[MIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Trim word with a random unused top bit
    function automatic logic [CFG_W-1:0] trim_word();
        int               t;
        logic [CFG_W-1:0] w;
        case ($urandom_range(0, 3))
            0:       t = -1023;
            1:       t = 1023;
            default: t = int'($urandom_range(0, 2046)) - 1023;
        endcase
        w           = CFG_W'($urandom);
        w[TRIM_W-1:0] = t[TRIM_W-1:0];
        return w;
    endfunction

    // Fresh register set, extremes drawn often
    task automatic new_settings();
        logic [CFG_W-1:0] w;
        case ($urandom_range(0, 3))
            0:       w = '0;
            1:       w = 12'hFFF;
            default: w = CFG_W'($urandom_range(0, 80));
        endcase
        write_reg(REG_DEAD_TIME, w);
        write_reg(REG_RISE_TRIM, trim_word());
        write_reg(REG_FALL_TRIM, trim_word());
        w = CFG_W'($urandom);
        case ($urandom_range(0, 3))
            0:       w[MIN_W-1:0] = '0;
            1:       w[MIN_W-1:0] = 10'h3FF;
            default: w[MIN_W-1:0] = MIN_W'($urandom_range(0, 60));
        endcase
        write_reg(REG_MIN_ACTIVE, w);
    endtask

    // One pattern of random steps; noisy ones flag last at random
    task automatic send_pattern(int n, bit noisy);
        logic [DUR_W-1:0]  dur;
        logic [DUR_W-1:0]  corr;
        logic [LANE_W-1:0] chg;
        bit                last;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    dur  = DUR_W'($urandom_range(0, 40));
                    corr = DUR_W'(int'($urandom_range(0, 40)) - 20);
                end
                1:
                begin
                    dur  = DUR_W'($urandom);
                    corr = '0;
                end
                2:
                begin
                    dur  = DUR_W'($urandom);
                    corr = DUR_W'($urandom);
                end
                default:
                begin
                    dur  = DUR_W'($urandom_range(0, 300));
                    corr = DUR_W'(-int'($urandom_range(0, 32768)));
                end
            endcase
            chg  = ($urandom_range(0, 3) == 0) ? '0 : LANE_W'($urandom_range(0, 63));
            last = noisy ? ($urandom_range(0, 3) == 0) : (k == n - 1);
            send_step(LANE_W'($urandom_range(0, 63)), chg, dur, corr,
                      1'($urandom_range(0, 1)), last, 1'b0, '0);
        end
    endtask

    // Close a pattern left open so the block can go idle
    task automatic close_pattern();
        if (held_valid)
            send_step(LANE_W'($urandom_range(0, 63)), LANE_W'($urandom_range(0, 63)),
                      DUR_W'($urandom_range(0, 500)), '0, 1'($urandom_range(0, 1)),
                      1'b1, 1'b0, '0);
    endtask

    function automatic void cmp_field(string what, logic [TOTAL_W-1:0] want,
                                      logic [TOTAL_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Check one accepted run beat against the oldest expectation
    task automatic take_run();
        run_t want;
        if (runs_due.size() == 0)
        begin
            errors++;
            $display("%0t: run beat with nothing expected: value %0h length %0d",
                     $time, lane_value, run_length);
        end
        else
        begin
            want = runs_due.pop_front();
            cmp_field("lane_value", TOTAL_W'(want.lane_value), TOTAL_W'(lane_value));
            cmp_field("run_length", TOTAL_W'(want.run_length), TOTAL_W'(run_length));
            cmp_field("dead_run", TOTAL_W'(want.dead_run), TOTAL_W'(dead_run));
            cmp_field("clamped", TOTAL_W'(want.clamped), TOTAL_W'(clamped));
            cmp_field("pattern_samples", want.pattern_samples, pattern_samples);
            cmp_field("final_run", TOTAL_W'(want.final_run), TOTAL_W'(final_run));
            runs_checked++;
            if (want.dead_run)
                dead_seen++;
            if (want.clamped)
                clamp_seen++;
        end
    endtask

    // Receiver: random pop, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (pop && !empty)
                take_run();
            if (hold_asks != hold_seen)
            begin
                hold_seen <= hold_asks;
                hold_left <= HOLD_CYCLES;
                pop       <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d runs still owed", $time, runs_due.size());
            $display("dead_time_pattern_run_generator_core regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int chunk_start;

        // Reset defaults: no dead time, no trims, floor of 20
        plan.push_back(step_row(6'h3F, 6'h00, 16'd100, 16'd0, 1'b0, 1'b1, 1'b1,
                                run_of(6'h3F, 200, 1'b0, 1'b0, 200, 1'b1)));
        plan.push_back(step_row(6'h00, 6'h3F, 16'd0, 16'h8000, 1'b1, 1'b1, 1'b1,
                                run_of(6'h00, 20, 1'b0, 1'b1, 2, 1'b1)));
        plan.push_back(step_row(6'h2A, 6'h15, 16'hFFFF, 16'h7FFF, 1'b0, 1'b1, 1'b1,
                                run_of(6'h2A, 196604, 1'b0, 1'b0, 196604, 1'b1)));
        plan.push_back(step_row(6'h15, 6'h2A, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1,
                                run_of(6'h15, 20, 1'b0, 1'b1, 2, 1'b1)));
        // exactly at the floor: not raised
        plan.push_back(step_row(6'h01, 6'h01, 16'd10, 16'd0, 1'b0, 1'b1, 1'b1,
                                run_of(6'h01, 20, 1'b0, 1'b0, 20, 1'b1)));
        plan.push_back(step_row(6'h3E, 6'h00, 16'd5, 16'd6, 1'b0, 1'b1, 1'b1,
                                run_of(6'h3E, 22, 1'b0, 1'b0, 22, 1'b1)));
        plan.push_back(step_row(6'h07, 6'h38, 16'd8, 16'hFFFD, 1'b1, 1'b1, 1'b1,
                                run_of(6'h07, 10 < 20 ? 20 : 10, 1'b0, 1'b1, 10, 1'b1)));
        // two-step pattern: opening step gives nothing
        plan.push_back(step_row(6'h0F, 6'h0F, 16'd50, 16'd0, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(step_row(6'h30, 6'h30, 16'd60, 16'hFFFB, 1'b0, 1'b1, 1'b0, '0));
        // moderate dead time and trims
        plan.push_back(cfg_row(REG_DEAD_TIME, 12'd40));
        plan.push_back(cfg_row(REG_RISE_TRIM, 12'd15));
        plan.push_back(cfg_row(REG_FALL_TRIM, 12'h7F7));
        plan.push_back(cfg_row(REG_MIN_ACTIVE, 12'd12));
        plan.push_back(step_row(6'h05, 6'h05, 16'd30, 16'd0, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(step_row(6'h0A, 6'h00, 16'd25, 16'd3, 1'b0, 1'b0, 1'b0, '0));
        plan.push_back(step_row(6'h30, 6'h3A, 16'd70, 16'hFFF6, 1'b0, 1'b1, 1'b0, '0));
        // one-step pattern with changing lanes wraps onto itself
        plan.push_back(step_row(6'h11, 6'h11, 16'd20, 16'd0, 1'b1, 1'b1, 1'b0, '0));
        // upper extremes of dead time, rise trim and min active; fall trim at -1023
        plan.push_back(cfg_row(REG_DEAD_TIME, 12'hFFF));
        plan.push_back(cfg_row(REG_RISE_TRIM, 12'h3FF));
        plan.push_back(cfg_row(REG_FALL_TRIM, 12'h401));
        plan.push_back(cfg_row(REG_MIN_ACTIVE, 12'h3FF));
        plan.push_back(step_row(6'h3F, 6'h3F, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(step_row(6'h00, 6'h3F, 16'd3, 16'd0, 1'b0, 1'b1, 1'b0, '0));
        // zero floor, trims drive the active run below zero
        plan.push_back(cfg_row(REG_DEAD_TIME, 12'd0));
        plan.push_back(cfg_row(REG_RISE_TRIM, 12'h401));
        plan.push_back(cfg_row(REG_FALL_TRIM, 12'h3FF));
        plan.push_back(cfg_row(REG_MIN_ACTIVE, 12'd0));
        plan.push_back(step_row(6'h2C, 6'h13, 16'd1, 16'hFFFF, 1'b1, 1'b0, 1'b0, '0));
        plan.push_back(step_row(6'h13, 6'h2C, 16'd0, 16'd5, 1'b0, 1'b1, 1'b0, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_step(plan[i].on, plan[i].chg, plan[i].dur, plan[i].corr, plan[i].rise,
                          plan[i].last, plan[i].typed, plan[i].want);
        end

        // Random part in three idling modes
        for (int mode = 0; mode < 3; mode++)
        begin
            drain();
            send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 61 : 0;
            recv_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 34 : 0;
            new_settings();
            if (mode == 1)
                send_pattern(STEP_CAP + 3, 1'b0);   // runs past the step cap
            if (mode == 2)
                hold_asks <= hold_asks + 1;         // back up the block
            chunk_start = steps_sent;
            while (steps_sent - chunk_start < CHUNK_STEPS)
            begin
                send_pattern($urandom_range(1, 6), $urandom_range(0, 7) == 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    close_pattern();
                    drain();
                    new_settings();
                end
            end
            close_pattern();
        end

        drain();
        $display("covered %0d steps in %0d patterns with %0d register writes",
                 steps_sent, patterns_done, reg_writes);
        $display("checked %0d runs: %0d dead-time, %0d raised to the floor",
                 runs_checked, dead_seen, clamp_seen);
        if (errors == 0)
            $display("dead_time_pattern_run_generator_core regression: pass");
        else
            $display("dead_time_pattern_run_generator_core regression: fail");
        $finish;
    end

endmodule
